/* sv/gps_pkg.sv */
// Shared types and constants for the gravity projected shock block.
// Used by the controller, the datapath and the top level.
package gps_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam logic [15:0] ALPHA_RST = 16'd1311;
  localparam logic [14:0] MIN_GRAVITY_RST = 15'd1;

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] ADDR_ALPHA = 3'd0;
  localparam logic [CFG_AW-1:0] ADDR_MIN_GRAVITY = 3'd4;

  // Iteration counts of the root and the quotient units.
  localparam int SQRT_STEPS = 24;
  localparam int DIV_STEPS = 17;
  localparam int CNT_W = 5;
  localparam logic [1:0] LAST_AXIS = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FMUL,
    ST_FADD,
    ST_SMUL,
    ST_SACC,
    ST_SQI,
    ST_SQRT,
    ST_CHK,
    ST_DMUL,
    ST_DACC,
    ST_DVI,
    ST_DIV,
    ST_FIN
  } gps_state_t;

  typedef struct packed {
    logic       load;
    logic       filt_mul;
    logic       filt_add;
    logic       mul;
    logic       sel_dot;
    logic       sq_acc;
    logic       dot_acc;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       out_load;
    logic [1:0] axis;
  } gps_cmd_t;

  typedef struct packed {
    logic weak_grav;
    logic out_busy;
  } gps_status_t;

endpackage

/* sv/gps_ctrl.sv */
// Sequencer of the gravity projected shock block.
// Depends on gps_pkg; drives the datapath through gps_cmd_t.
module gps_ctrl import gps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  gps_status_t status,
  output gps_cmd_t    cmd
);

  gps_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    cmd.axis = cnt_r[1:0];
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          cnt_nxt = '0;
          state_nxt = ST_FMUL;
        end
      end
      ST_FMUL: begin
        cmd.filt_mul = 1'b1;
        state_nxt = ST_FADD;
      end
      ST_FADD: begin
        cmd.filt_add = 1'b1;
        if (cnt_r[1:0] == LAST_AXIS) begin
          cnt_nxt = '0;
          state_nxt = ST_SMUL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = ST_FMUL;
        end
      end
      ST_SMUL: begin
        cmd.mul = 1'b1;
        state_nxt = ST_SACC;
      end
      ST_SACC: begin
        cmd.sq_acc = 1'b1;
        if (cnt_r[1:0] == LAST_AXIS) begin
          cnt_nxt = '0;
          state_nxt = ST_SQI;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = ST_SMUL;
        end
      end
      ST_SQI: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          cnt_nxt = '0;
          state_nxt = ST_CHK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_CHK: begin
        cnt_nxt = '0;
        state_nxt = status.weak_grav ? ST_FIN : ST_DMUL;
      end
      ST_DMUL: begin
        cmd.mul = 1'b1;
        cmd.sel_dot = 1'b1;
        state_nxt = ST_DACC;
      end
      ST_DACC: begin
        cmd.dot_acc = 1'b1;
        if (cnt_r[1:0] == LAST_AXIS) begin
          cnt_nxt = '0;
          state_nxt = ST_DVI;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = ST_DMUL;
        end
      end
      ST_DVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt = '0;
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FIN: begin
        // Wait for the output register to be free.
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/gps_datapath.sv */
// Datapath of the gravity projected shock block: gravity filter, squares,
// bit-pair square root, dot product, restoring divider and output register.
// Depends on gps_pkg; controlled by gps_ctrl through gps_cmd_t.
module gps_datapath import gps_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic [15:0]        alpha,
  input  logic [14:0]        min_gravity,
  input  gps_cmd_t           cmd,
  output gps_status_t        status,
  input  logic               out_tready,
  output logic               out_tvalid,
  output logic signed [15:0] out_shock,
  output logic               out_weak,
  output logic               out_clipped
);

  localparam int GW = FRAC_BITS + 18;
  localparam int PW = GW + 17;
  localparam int GS_LSB = FRAC_BITS - 8;

  logic signed [15:0] a_r [3];
  logic signed [GW-1:0] g_r [3];
  logic zero_r;
  logic signed [PW-1:0] prod_r;
  logic signed [49:0] mprod_r;
  logic [47:0] sum_r, sh_r;
  logic [25:0] rem_r;
  logic [23:0] root_r;
  logic signed [50:0] dot_r;
  logic [50:0] num_r;
  logic [47:0] dv_r;
  logic [16:0] q_r;
  logic big_r, neg_r;
  logic out_valid_r;
  logic signed [15:0] shock_r;
  logic weak_r, clip_r;

  logic signed [15:0] a_sel;
  logic signed [GW-1:0] g_sel, a_ext, diff, g_new;
  logic signed [23:0] gs_sel;
  logic signed [24:0] d_sel, opa;
  logic [27:0] rem2, trial;
  logic [31:0] divisor;
  logic [50:0] num_c;
  logic signed [15:0] shock_c;
  logic clip_c;

  always_comb begin
    a_sel = a_r[cmd.axis];
    g_sel = g_r[cmd.axis];
    a_ext = GW'(a_sel);
    diff = (a_ext <<< FRAC_BITS) - g_sel;
    g_new = g_sel + GW'(prod_r >>> 16);
    gs_sel = g_sel[GS_LSB +: 24];
    d_sel = (25'(a_sel) <<< 8) - 25'(gs_sel);
    opa = cmd.sel_dot ? d_sel : 25'(gs_sel);
    rem2 = {rem_r, sh_r[47:46]};
    trial = {2'b00, root_r, 2'b01};
    divisor = {root_r, 8'h00};
    num_c = dot_r[50] ? 51'(-dot_r) : 51'(dot_r);
    status.weak_grav = (root_r == '0) || (root_r < {1'b0, min_gravity, 8'h00});
    status.out_busy = out_valid_r && !out_tready;
    // Saturate the truncated quotient to the 16-bit range.
    if (neg_r) begin
      if (big_r || q_r > 17'd32768) begin
        shock_c = 16'sh8000;
        clip_c = 1'b1;
      end else begin
        shock_c = 16'(-q_r);
        clip_c = 1'b0;
      end
    end else begin
      if (big_r || q_r > 17'd32767) begin
        shock_c = 16'sh7fff;
        clip_c = 1'b1;
      end else begin
        shock_c = 16'(q_r);
        clip_c = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r[0] <= accel_x;
      a_r[1] <= accel_y;
      a_r[2] <= accel_z;
      zero_r <= (g_r[0] == '0) && (g_r[1] == '0) && (g_r[2] == '0);
      sum_r <= '0;
      dot_r <= '0;
    end
    if (cmd.filt_mul) begin
      prod_r <= $signed({1'b0, alpha}) * diff;
    end
    if (cmd.mul) begin
      mprod_r <= opa * 25'(gs_sel);
    end
    if (cmd.sq_acc) begin
      sum_r <= sum_r + mprod_r[47:0];
    end
    if (cmd.dot_acc) begin
      dot_r <= dot_r + 51'(mprod_r);
    end
    if (cmd.sqrt_init) begin
      sh_r <= sum_r;
      rem_r <= '0;
      root_r <= '0;
    end
    if (cmd.sqrt_step) begin
      sh_r <= sh_r << 2;
      if (rem2 >= trial) begin
        rem_r <= 26'(rem2 - trial);
        root_r <= {root_r[22:0], 1'b1};
      end else begin
        rem_r <= rem2[25:0];
        root_r <= {root_r[22:0], 1'b0};
      end
    end
    if (cmd.div_init) begin
      num_r <= num_c;
      neg_r <= dot_r[50];
      big_r <= num_c >= (51'(divisor) << 17);
      dv_r <= 48'(divisor) << 16;
      q_r <= '0;
    end
    if (cmd.div_step) begin
      dv_r <= dv_r >> 1;
      if (num_r >= 51'(dv_r)) begin
        num_r <= num_r - 51'(dv_r);
        q_r <= {q_r[15:0], 1'b1};
      end else begin
        q_r <= {q_r[15:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      if (status.weak_grav) begin
        shock_r <= '0;
        weak_r <= 1'b1;
        clip_r <= 1'b0;
      end else begin
        shock_r <= shock_c;
        weak_r <= 1'b0;
        clip_r <= clip_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_r[0] <= '0;
      g_r[1] <= '0;
      g_r[2] <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.filt_add) begin
        // An all-zero estimate takes the sample unfiltered.
        g_r[cmd.axis] <= zero_r ? (a_ext <<< FRAC_BITS) : g_new;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_shock = shock_r;
  assign out_weak = weak_r;
  assign out_clipped = clip_r;

endmodule

/* sv/gravity_projected_shock.sv */
// Top level of the gravity projected shock block: configuration registers,
// stream ports, controller and datapath. Depends on gps_pkg, gps_ctrl, gps_datapath.
//
// Usage:
//  - in_*: one three-axis sample per transfer, x in the low 16 bits of tdata.
//  - out_*: one result per sample: shock in tdata, weak_gravity and clipped
//    in tuser.
//  - cfg_*: APB registers, alpha at 0x0 and min_gravity at 0x4. Write only
//    while no sample is in flight.
//  - A sample is taken, then runs the filter update, the sums of squares, the
//    square root (setup, then one result bit per cycle), the weak check, the
//    dot product, the restoring division (setup, then one quotient bit per
//    cycle) and the output load, which waits while the output register is
//    busy; the next sample can be accepted in the cycle after the output load.
//    A weak gravity estimate skips the dot product and division.
//  - The output register holds its result while out_tready is low; the next
//    sample may be accepted meanwhile and waits at its end for the register.
//  - Reset clears the gravity estimate, so the first sample loads it directly,
//    and restores alpha to 1311 and min_gravity to 1.
module gravity_projected_shock import gps_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,    // accel_x, accel_y, accel_z
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,   // shock
  output logic [1:0]        out_tuser,   // weak_gravity, clipped
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [15:0] alpha_r;
  logic [14:0] min_gravity_r;
  logic cfg_wr;
  gps_cmd_t cmd;
  gps_status_t status;
  logic signed [15:0] shock;
  logic weak_grav, clipped;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RST;
      min_gravity_r <= MIN_GRAVITY_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr == ADDR_ALPHA) begin
        alpha_r <= cfg_pwdata[15:0];
      end else if (cfg_paddr == ADDR_MIN_GRAVITY) begin
        min_gravity_r <= cfg_pwdata[14:0];
      end
    end
  end

  always_comb begin
    case (cfg_paddr)
      ADDR_ALPHA: cfg_prdata = {16'h0000, alpha_r};
      ADDR_MIN_GRAVITY: cfg_prdata = {17'h00000, min_gravity_r};
      default: cfg_prdata = '0;
    endcase
  end

  gps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  gps_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .accel_x     (in_tdata[15:0]),
    .accel_y     (in_tdata[31:16]),
    .accel_z     (in_tdata[47:32]),
    .alpha       (alpha_r),
    .min_gravity (min_gravity_r),
    .cmd         (cmd),
    .status      (status),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_shock   (shock),
    .out_weak    (weak_grav),
    .out_clipped (clipped)
  );

  assign out_tdata = shock;
  assign out_tuser = {clipped, weak_grav};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  a_weak_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 16'h0000 && !out_tuser[1])
    else $error("weak result not zero");

  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == 16'h7fff || out_tdata == 16'h8000)
    else $error("clipped result off the rail");

endmodule
